[hw/rtl/hfe_pkg.sv]
package hfe_pkg;

    localparam int COUNT_BITS_DEF    = 20;
    localparam int FRACTION_BITS_DEF = 31;
    localparam int CELL_BITS         = 4;
    localparam int PASS_BITS         = 17;
    localparam int NUM_GENO          = 9;
    localparam int NUM_HAPLO         = 4;

    localparam logic [31:0]          TOL_RESET  = 32'd215;
    localparam logic [PASS_BITS-1:0] ITER_RESET = 17'd100000;

    localparam logic ADDR_TOL  = 1'b0;
    localparam logic ADDR_ITER = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NO_CONV = 2'd2;

    typedef struct packed {
        logic [CELL_BITS-1:0] cell_req;
        logic [19:0]          count;
        logic                 last;
    } t_in_word;

    typedef struct packed {
        logic [31:0]          freq_01;
        logic [31:0]          freq_10;
        logic [31:0]          freq_11;
        logic [1:0]           status;
        logic [PASS_BITS-1:0] passes;
    } t_out_word;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SUMS,
        S_EST_MUL,
        S_EST_DIV,
        S_EST_WAIT,
        S_SPL_MUL_A,
        S_SPL_MUL_B,
        S_SPL_DIV,
        S_SPL_WAIT,
        S_CHECK,
        S_OUT
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

endpackage

[hw/rtl/hfe_divider.sv]
module hfe_divider #(
    parameter int W  = 96,
    parameter int QW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hfe_pkg::t_div_ctl    i_ctl,
    input  logic [W-1:0]         i_num,
    input  logic [W-1:0]         i_den,
    output logic                 o_done,
    output logic [QW-1:0]        o_quot
);
    import hfe_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_num, n_num;
    logic [W-1:0]  r_den;
    logic [W:0]    r_rem, n_rem;
    logic [QW-1:0] r_quot, n_quot;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    assign w_shift = {r_rem[W-1:0], r_num[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_quot = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[W-2:0], 1'b0};
            if (!w_diff[W]) begin
                n_rem  = w_diff;
                n_quot = {r_quot[QW-2:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_ctl.start) r_den <= i_den;
    end

    // zero divisor yields zero
    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '0 : r_quot;

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ctl.start) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("divider count slip");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> r_busy) else $error("divider not started");

endmodule

[hw/rtl/haplotype_frequency_em.sv]
// Two-locus haplotype frequency EM. Table cells are taken one word per cycle
// while ready is high. A word with last set starts estimation and ready falls
// until the result word is taken. Each estimate is four quotients and each
// EM pass adds one split-fraction quotient, all on one shared restoring
// divider of DW = max(2*FRACTION_BITS+2, COUNT_BITS+5)+FRACTION_BITS+1 bits
// (96 at the defaults), one bit a cycle; products go through one multiplier.
// After the last cell the S_SUMS state forms the sums, then the first estimate
// runs, and EM passes follow, each pass skipping its split-fraction quotient
// when f00*f11 is zero, up to max_iterations passes. The result word holds
// until taken. No clearing pass after reset.
module haplotype_frequency_em #(
    parameter int COUNT_BITS    = hfe_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = hfe_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hfe_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hfe_pkg::t_out_word  o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hfe_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int CB = COUNT_BITS + 5;          // allele sums and total
    localparam int FW = FB + 1;                  // Q1.FB
    localparam int PW = 2 * FW;                  // product of two frequencies
    localparam int EW = COUNT_BITS + FW;         // double het share
    localparam int DW = (PW > CB ? PW : CB) + FB + 1;  // divider width
    localparam int MW = (FW > CB ? FW : CB);

    logic [31:0]          r_tol;
    logic [PASS_BITS-1:0] r_iter;

    logic [COUNT_BITS-1:0] r_g [NUM_GENO];
    logic [COUNT_BITS-1:0] r_h [NUM_HAPLO];
    logic [CB-1:0]         r_c [4];
    logic [CB-1:0]         r_total;
    logic [FW-1:0]         r_f [4];
    logic [FW-1:0]         r_pf [4];
    logic [FW-1:0]         r_p;
    logic [EW-1:0]         r_e00;
    logic [PW-1:0]         r_pa;
    logic [1:0]            r_idx;
    logic [PASS_BITS-1:0]  r_pass;
    logic [1:0]            r_status;
    logic                  r_first;
    t_state                r_state, n_state;

    t_div_ctl             w_ctl;
    logic [DW-1:0]        w_num, w_den;
    logic                 w_done;
    logic [63:0]          w_quot;
    logic [MW-1:0]        w_ma, w_mb;
    logic [2*MW-1:0]      w_prod;
    logic [EW-1:0]        w_e01;
    logic [DW-1:0]        w_shnum;
    logic                 w_empty, w_conv;
    logic [FW-1:0]        w_tol, w_d [4];
    logic [PASS_BITS-1:0] w_lim;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            ADDR_TOL: prdata = r_tol;
            default:  prdata = {{(32-PASS_BITS){1'b0}}, r_iter};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= TOL_RESET;
            r_iter <= ITER_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_TOL) r_tol <= pwdata;
            else if (paddr[2] == ADDR_ITER) r_iter <= pwdata[PASS_BITS-1:0];
        end
    end

    // shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_EST_MUL: begin
                w_ma = MW'(r_g[4]);
                w_mb = MW'(r_p);
            end
            S_SPL_MUL_A: begin
                w_ma = MW'(r_f[0]);
                w_mb = MW'(r_f[3]);
            end
            S_SPL_MUL_B, S_SPL_DIV: begin
                w_ma = MW'(r_f[1]);
                w_mb = MW'(r_f[2]);
            end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_e01   = (EW'(r_g[4]) << FB) - r_e00;
    assign w_shnum = (DW'(r_c[r_idx]) << FB)
                   + DW'((r_idx == 2'd0 || r_idx == 2'd3) ? r_e00 : w_e01);

    always_comb begin
        w_ctl.start = 1'b0;
        w_num = w_shnum;
        w_den = DW'(r_total);
        unique case (r_state)
            S_EST_DIV: w_ctl.start = 1'b1;
            S_SPL_DIV: begin
                w_ctl.start = 1'b1;
                w_num = DW'(r_pa) << FB;
                w_den = DW'(r_pa) + DW'(w_prod[PW-1:0]);
            end
            default: ;
        endcase
    end

    hfe_divider #(.W(DW), .QW(64)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    always_comb begin
        w_empty = 1'b1;
        for (int i = 0; i < NUM_GENO; i++) if (r_g[i] != '0) w_empty = 1'b0;
    end

    always_comb begin
        w_tol = (FB >= 31) ? FW'({32'd0, r_tol} << (FB - 31))
                           : FW'(r_tol >> (31 - FB));
        w_conv = 1'b1;
        for (int i = 0; i < 4; i++) begin
            w_d[i] = (r_f[i] > r_pf[i]) ? r_f[i] - r_pf[i] : r_pf[i] - r_f[i];
            if (w_d[i] > w_tol) w_conv = 1'b0;
        end
    end
    assign w_lim = (r_iter == '0) ? PASS_BITS'(1) : r_iter;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:      if (i_valid && i_data.last) n_state = S_SUMS;
            S_SUMS:      n_state = w_empty ? S_OUT : S_EST_MUL;
            S_EST_MUL:   n_state = S_EST_DIV;
            S_EST_DIV:   n_state = S_EST_WAIT;
            S_EST_WAIT: begin
                if (w_done) begin
                    if (r_idx != 2'd3) n_state = S_EST_DIV;
                    else if (r_first) n_state = (r_g[4] == '0) ? S_OUT : S_SPL_MUL_A;
                    else n_state = S_CHECK;
                end
            end
            S_SPL_MUL_A: n_state = S_SPL_MUL_B;
            S_SPL_MUL_B: n_state = (r_pa == '0) ? S_EST_MUL : S_SPL_DIV;
            S_SPL_DIV:   n_state = S_SPL_WAIT;
            S_SPL_WAIT:  if (w_done) n_state = S_EST_MUL;
            S_CHECK:     n_state = (w_conv || r_pass >= w_lim) ? S_OUT : S_SPL_MUL_A;
            S_OUT:       if (i_ready) n_state = S_LOAD;
            default:     n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_LOAD);
        o_valid = (r_state == S_OUT);
        o_data.freq_01 = 32'((FB >= 31) ? (64'(r_f[1]) >> (FB - 31))
                                        : (64'(r_f[1]) << (31 - FB)));
        o_data.freq_10 = 32'((FB >= 31) ? (64'(r_f[2]) >> (FB - 31))
                                        : (64'(r_f[2]) << (31 - FB)));
        o_data.freq_11 = 32'((FB >= 31) ? (64'(r_f[3]) >> (FB - 31))
                                        : (64'(r_f[3]) << (31 - FB)));
        o_data.status = r_status;
        o_data.passes = r_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_pass   <= '0;
            r_status <= ST_OK;
            r_idx    <= '0;
            r_first  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_f[i]  <= '0;
                r_pf[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (i_data.cell_req < CELL_BITS'(NUM_GENO))
                            r_g[i_data.cell_req] <= COUNT_BITS'(i_data.count);
                        else if (i_data.cell_req < CELL_BITS'(NUM_GENO + NUM_HAPLO))
                            r_h[2'(i_data.cell_req - CELL_BITS'(NUM_GENO))] <=
                                COUNT_BITS'(i_data.count);
                    end
                end
                S_SUMS: begin
                    r_pass   <= '0;
                    r_first  <= 1'b1;
                    r_p      <= FW'(1) << (FB - 1);
                    r_status <= w_empty ? ST_EMPTY : ST_OK;
                    if (w_empty) begin
                        for (int i = 0; i < 4; i++) begin
                            r_f[i]  <= '0;
                            r_pf[i] <= '0;
                        end
                    end
                    r_c[0] <= CB'(r_h[0]) + CB'(r_g[1]) + (CB'(r_g[0]) << 1) + CB'(r_g[3]);
                    r_c[1] <= CB'(r_h[1]) + CB'(r_g[1]) + (CB'(r_g[2]) << 1) + CB'(r_g[5]);
                    r_c[2] <= CB'(r_h[2]) + CB'(r_g[7]) + (CB'(r_g[6]) << 1) + CB'(r_g[3]);
                    r_c[3] <= CB'(r_h[3]) + CB'(r_g[5]) + (CB'(r_g[8]) << 1) + CB'(r_g[7]);
                    r_total <= CB'(r_h[0]) + CB'(r_h[1]) + CB'(r_h[2]) + CB'(r_h[3])
                             + CB'(r_g[1]) + (CB'(r_g[1]) >> 0) + CB'(r_g[5])
                             + CB'(r_g[5]) + CB'(r_g[3]) + CB'(r_g[3])
                             + CB'(r_g[7]) + CB'(r_g[7])
                             + ((CB'(r_g[0]) + CB'(r_g[2]) + CB'(r_g[4])
                                 + CB'(r_g[6]) + CB'(r_g[8])) << 1);
                end
                S_EST_MUL: begin
                    r_e00 <= w_prod[EW-1:0];
                    r_idx <= '0;
                end
                S_EST_WAIT: begin
                    if (w_done) begin
                        r_f[r_idx] <= FW'(w_quot);
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SPL_MUL_A: begin
                    r_first <= 1'b0;
                    r_pa    <= w_prod[PW-1:0];
                    for (int i = 0; i < 4; i++) r_pf[i] <= r_f[i];
                    r_pass  <= r_pass + 1'b1;
                    r_p     <= '0;
                end
                S_SPL_WAIT: if (w_done) r_p <= FW'(w_quot);
                S_CHECK: if (!w_conv && r_pass >= w_lim) r_status <= ST_NO_CONV;
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready during result");
    a_pass_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_NO_CONV) |-> (o_data.passes == w_lim))
        else $error("pass limit slip");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_EMPTY) |-> (o_data.passes == '0))
        else $error("empty with passes");

endmodule
